### src/tagged_record_loader_crc16_defines.svh
// Assertion macros for the tagged record loader.
`ifndef TAGGED_RECORD_LOADER_CRC16_DEFINES_SVH
`define TAGGED_RECORD_LOADER_CRC16_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset only
`define TRLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("trlc: assertion failed");
// checked on every edge, reset included
`define TRLC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("trlc: assertion failed");
`else
`define TRLC_ASSERT(lbl, prop)
`define TRLC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### src/trlcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package trlcrc_pkg;

  localparam int SLOT_MAX = 4;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;
  typedef logic [SLOT_MAX-1:0][31:0] slot_vals_t;
  typedef logic [SLOT_MAX-1:0][7:0]  tag_regs_t;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_RECORDS = 2'd1;
  localparam logic [1:0] PH_CRC_HI  = 2'd2;
  localparam logic [1:0] PH_CRC_LO  = 2'd3;

  localparam logic [2:0] CFG_TAG_SLOT0 = 3'd0;
  localparam logic [2:0] CFG_TAG_SLOT1 = 3'd1;
  localparam logic [2:0] CFG_TAG_SLOT2 = 3'd2;
  localparam logic [2:0] CFG_TAG_SLOT3 = 3'd3;

  localparam crc_t  CRC_INIT = 16'hFFFF;
  localparam crc_t  CRC_POLY = 16'hA001;
  localparam byte_t TAG_END  = 8'hFF;

  localparam tag_regs_t TAG_RESET = {8'd99, 8'd70, 8'd102, 8'd117};

  // CRC-16/MODBUS, one byte, LSB first
  function automatic crc_t crc16_update(input crc_t c_in, input byte_t b);
    crc_t c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### src/tagged_record_loader_crc16.sv
`timescale 1ns / 1ps
`default_nettype none
// Loads a tagged parameter image, one byte per transfer, and checks its CRC-16/MODBUS
// (init 0xFFFF, reflected poly 0xA001) stored high byte first after the 0xFF terminator
// or after REGION_BYTES of records. Records whose tag matches tag_slot0..3 are staged;
// the staged values are committed only when the CRC matches. start_image on a byte
// abandons any image in flight and takes that byte as the first tag. One result is
// produced on the CRC low byte; a new byte is taken every cycle unless a blocked result
// stalls the input, the per-byte work being an eight-step CRC byte update and four tag
// compares in one stage between the input register and the result register.
`include "tagged_record_loader_crc16_defines.svh"
module tagged_record_loader_crc16
  import trlcrc_pkg::*;
#(
  parameter int REGION_BYTES      = 64,
  parameter int RECORD_DATA_BYTES = 4,
  parameter int NUM_SLOTS         = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_image,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             crc_ok,
  output logic [3:0]       found_mask,
  output logic [15:0]      computed_crc,
  output logic [15:0]      stored_crc,
  output logic [31:0]      value_slot0,
  output logic [31:0]      value_slot1,
  output logic [31:0]      value_slot2,
  output logic [31:0]      value_slot3
);

  localparam int RC_W  = $clog2(REGION_BYTES + 1);
  localparam int BIR_W = $clog2(RECORD_DATA_BYTES + 1);

  tag_regs_t tag_reg;

  // input register
  logic  q_vld;
  byte_t q_byte;
  logic  q_start;

  // image state
  logic [1:0]       phase,        phase_next;
  crc_t             running_crc,  running_crc_next;
  logic [BIR_W-1:0] byte_in_rec,  byte_in_rec_next;
  logic [RC_W-1:0]  region_count, region_count_next;
  logic [3:0]       matched_slot, matched_slot_next;
  byte_t            crc_high,     crc_high_next;
  slot_vals_t       staged,       staged_next;
  logic [3:0]       staged_found, staged_found_next;
  slot_vals_t       committed,    committed_next;

  logic       produce;
  logic       res_ok;
  crc_t       res_stored;
  slot_vals_t res_vals;
  logic       adv;
  logic       fire;
  logic       load;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_reg <= TAG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TAG_SLOT0: tag_reg[0] <= cfg_data;
        CFG_TAG_SLOT1: tag_reg[1] <= cfg_data;
        CFG_TAG_SLOT2: tag_reg[2] <= cfg_data;
        CFG_TAG_SLOT3: tag_reg[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [1:0]       ph_e;
    logic [BIR_W-1:0] bir_e;
    logic [RC_W-1:0]  rc_e;
    logic [3:0]       ms_e;
    logic [3:0]       hit;
    logic [2:0]       y;
    phase_next        = phase;
    running_crc_next  = running_crc;
    byte_in_rec_next  = byte_in_rec;
    region_count_next = region_count;
    matched_slot_next = matched_slot;
    crc_high_next     = crc_high;
    staged_next       = staged;
    staged_found_next = staged_found;
    committed_next    = committed;
    produce           = 1'b0;
    res_stored        = {crc_high, q_byte};
    res_ok            = (res_stored == running_crc);
    hit               = '0;
    y                 = '0;

    // a start marker rewinds to a fresh image before the byte is looked at
    ph_e  = phase;
    bir_e = byte_in_rec;
    rc_e  = region_count;
    ms_e  = matched_slot;
    if (q_start) begin
      ph_e              = PH_RECORDS;
      bir_e             = '0;
      rc_e              = '0;
      ms_e              = '0;
      running_crc_next  = CRC_INIT;
      staged_found_next = '0;
      staged_next       = committed;
      res_stored        = {8'h00, q_byte};
      res_ok            = 1'b0;
    end
    phase_next        = ph_e;
    byte_in_rec_next  = bir_e;
    region_count_next = rc_e;
    matched_slot_next = ms_e;

    case (ph_e)
      PH_RECORDS: begin
        if (bir_e == '0) begin
          if (rc_e >= RC_W'(REGION_BYTES)) begin
            crc_high_next = q_byte;
            phase_next    = PH_CRC_LO;
          end else begin
            running_crc_next  = crc16_update(running_crc_next, q_byte);
            region_count_next = rc_e + RC_W'(1);
            if (q_byte == TAG_END) begin
              phase_next = PH_CRC_HI;
            end else begin
              for (int j = 0; j < SLOT_MAX; j++) begin
                if (j < NUM_SLOTS) hit[j] = (q_byte == tag_reg[j]);
              end
              matched_slot_next = hit;
              staged_found_next = staged_found_next | hit;
              byte_in_rec_next  = BIR_W'(1);
            end
          end
        end else begin
          running_crc_next = crc16_update(running_crc_next, q_byte);
          if (rc_e < RC_W'(REGION_BYTES)) region_count_next = rc_e + RC_W'(1);
          y = 3'(bir_e) - 3'd1;
          // only the first four data bytes land in a slot
          if (!y[2]) begin
            for (int j = 0; j < SLOT_MAX; j++) begin
              if (ms_e[j]) staged_next[j][{y[1:0], 3'b000} +: 8] = q_byte;
            end
          end
          if (bir_e >= BIR_W'(RECORD_DATA_BYTES)) begin
            byte_in_rec_next  = '0;
            matched_slot_next = '0;
          end else begin
            byte_in_rec_next = bir_e + BIR_W'(1);
          end
        end
      end
      PH_CRC_HI: begin
        crc_high_next = q_byte;
        phase_next    = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        produce           = 1'b1;
        phase_next        = PH_IDLE;
        byte_in_rec_next  = '0;
        matched_slot_next = '0;
        if (res_ok) committed_next = staged;
      end
      default: ;
    endcase

    for (int j = 0; j < SLOT_MAX; j++) begin
      res_vals[j] = (j < NUM_SLOTS) ? committed_next[j] : 32'd0;
    end
  end

  // the byte may leave the input register unless it carries a result that cannot be placed
  assign adv      = !(produce && out_valid && out_stall);
  assign fire     = q_vld && adv;
  assign load     = fire && produce;
  assign in_stall = q_vld && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= (in_valid && !in_stall) || (q_vld && !adv);
    end
    if (in_valid && !in_stall) begin
      q_byte  <= data_byte;
      q_start <= start_image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      running_crc  <= CRC_INIT;
      byte_in_rec  <= '0;
      region_count <= '0;
      matched_slot <= '0;
      staged_found <= '0;
      committed    <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      running_crc  <= running_crc_next;
      byte_in_rec  <= byte_in_rec_next;
      region_count <= region_count_next;
      matched_slot <= matched_slot_next;
      staged_found <= staged_found_next;
      committed    <= committed_next;
    end
    if (fire) begin
      crc_high <= crc_high_next;
      staged   <= staged_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      crc_ok       <= res_ok;
      found_mask   <= staged_found;
      computed_crc <= running_crc;
      stored_crc   <= res_stored;
      value_slot0  <= res_vals[0];
      value_slot1  <= res_vals[1];
      value_slot2  <= res_vals[2];
      value_slot3  <= res_vals[3];
    end
  end

  `TRLC_ASSERT_ALWAYS(a_idle_after_reset, rst |=> (!out_valid && !q_vld))
  `TRLC_ASSERT(a_ok_means_match, out_valid |-> (crc_ok == (stored_crc == computed_crc)))
  `TRLC_ASSERT(a_ok_committed, (out_valid && crc_ok) |-> (value_slot0 == committed[0]))
  `TRLC_ASSERT(a_blocked_result_stalls, (q_vld && produce && out_valid && out_stall) |-> in_stall)
  `TRLC_ASSERT(a_idle_no_record, (phase == PH_IDLE) |-> (byte_in_rec == '0 && matched_slot == '0))

endmodule
`default_nettype wire
